// ===== design/mfs_pkg.sv =====
`default_nettype none

package mfs_pkg;

  localparam logic [2:0] OP_TRAIN    = 3'd0;
  localparam logic [2:0] OP_WR_USER  = 3'd1;
  localparam logic [2:0] OP_WR_ITEM  = 3'd2;
  localparam logic [2:0] OP_RD_USER  = 3'd3;
  localparam logic [2:0] OP_RD_ITEM  = 3'd4;
  localparam logic [2:0] OP_EPOCH    = 3'd5;

  localparam logic [1:0] CFG_STEP_SIZE  = 2'd0;
  localparam logic [1:0] CFG_DECAY_BASE = 2'd1;
  localparam logic [1:0] CFG_MEAN_OFS   = 2'd2;
  localparam logic [1:0] CFG_REG_EN     = 2'd3;

  localparam logic [31:0] RST_STEP_SIZE  = 32'd214748;
  localparam logic [31:0] RST_DECAY_BASE = 32'd2147483645;
  localparam logic [31:0] ONE_Q31        = 32'h8000_0000;

  typedef logic signed [65:0] wide_t;
  typedef logic signed [32:0] mop_t;

  localparam wide_t MAX32 = 66'sd2147483647;
  localparam wide_t MIN32 = -66'sd2147483648;

  typedef enum logic [2:0] {
    K_NOP, K_TRAIN, K_WU, K_WI, K_RU, K_RI, K_EPOCH
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [15:0]        user_index;
    logic [13:0]        item_index;
    logic signed [31:0] rating;
    logic [23:0]        seq_order;
    logic [2:0]         element_index;
    logic signed [31:0] load_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] prediction_error;
    logic signed [31:0] read_value;
  } res_t;

  typedef struct packed {
    logic [31:0]        step_size;
    logic [31:0]        decay_base;
    logic signed [31:0] mean_offset;
    logic               reg_en;
  } cfg_t;

  function automatic wide_t rnd(input wide_t x, input int n);
    return (x + (wide_t'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t x);
    if (x > MAX32) return 32'sh7fff_ffff;
    if (x < MIN32) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic mop_t sx(input logic [31:0] x);
    return mop_t'({x[31], x});
  endfunction

  function automatic mop_t ux(input logic [31:0] x);
    return mop_t'({1'b0, x});
  endfunction

endpackage

`default_nettype wire

// ===== design/matrix_factorization_sgd_step.sv =====
`default_nettype none

// SGD step for matrix factorization with lazy L2 decay.
// Input words enter through push/full; results leave through empty/pop, one
// result word per input word, in order. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data); the user must write it only while the block
// is idle, and the block itself does not enforce this.
// A front stage classifies each word into a two-entry command queue; the back
// sequencer executes commands one at a time on a single shared 33x33
// multiplier and pushes results into a two-entry result queue.
// Train fetches both factor rows, forms their dot product and error, then
// updates each element of both rows. With decay on it first raises the decay
// base to the power of each row's skipped orders, one exponent bit at a time
// up to 24 bits, on the shared multiplier.
// Start epoch clears the order stores, one row per cycle. After reset the
// same clearing pass runs before the first word is taken. A stalled
// receiver fills the result queue, then the back sequencer waits, then the
// command queue fills and full rises.

module matrix_factorization_sgd_step #(
  parameter int RANK  = 8,
  parameter int USERS = 65536,
  parameter int ITEMS = 16384
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [2:0]         in_operation,
  input  wire logic [15:0]        in_user_index,
  input  wire logic [13:0]        in_item_index,
  input  wire logic signed [31:0] in_rating,
  input  wire logic [23:0]        in_update_order,
  input  wire logic [2:0]         in_element_index,
  input  wire logic signed [31:0] in_load_value,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [31:0]      out_prediction_error,
  output logic signed [31:0]      out_read_value,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import mfs_pkg::*;

  cfg_t cfg_r;
  cmd_t fr_cmd, cq_cmd;
  res_t bk_res, rq_res;
  logic cq_push, cq_full, cq_pop, cq_empty;
  logic rq_push, rq_full;
  logic [$bits(cmd_t)-1:0] cq_rdata;
  logic [$bits(res_t)-1:0] rq_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_size   <= RST_STEP_SIZE;
      cfg_r.decay_base  <= RST_DECAY_BASE;
      cfg_r.mean_offset <= '0;
      cfg_r.reg_en      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_SIZE:  cfg_r.step_size   <= cfg_data;
        CFG_DECAY_BASE: cfg_r.decay_base  <= cfg_data;
        CFG_MEAN_OFS:   cfg_r.mean_offset <= cfg_data;
        CFG_REG_EN:     cfg_r.reg_en      <= cfg_data[0];
        default:        cfg_r.reg_en      <= cfg_r.reg_en;
      endcase
    end
  end

  mfs_front #(.RANK(RANK), .USERS(USERS), .ITEMS(ITEMS)) u_front (
    .in_push          (in_push),
    .in_operation     (in_operation),
    .in_user_index    (in_user_index),
    .in_item_index    (in_item_index),
    .in_rating        (in_rating),
    .in_update_order  (in_update_order),
    .in_element_index (in_element_index),
    .in_load_value    (in_load_value),
    .cq_full          (cq_full),
    .cq_push          (cq_push),
    .cmd              (fr_cmd)
  );

  mfs_fifo #(.W($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (fr_cmd),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  assign cq_cmd  = cmd_t'(cq_rdata);
  assign in_full = cq_full;

  mfs_back #(.RANK(RANK), .USERS(USERS), .ITEMS(ITEMS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cq_empty (cq_empty),
    .cq_cmd   (cq_cmd),
    .cq_pop   (cq_pop),
    .res_full (rq_full),
    .res_push (rq_push),
    .res      (bk_res)
  );

  mfs_fifo #(.W($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (bk_res),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .empty (out_empty)
  );

  assign rq_res               = res_t'(rq_rdata);
  assign out_prediction_error = rq_res.prediction_error;
  assign out_read_value       = rq_res.read_value;

endmodule

`default_nettype wire

// ===== design/mfs_fifo.sv =====
`default_nettype none

module mfs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== design/mfs_front.sv =====
`default_nettype none

module mfs_front #(
  parameter int RANK  = 8,
  parameter int USERS = 65536,
  parameter int ITEMS = 16384
) (
  input  wire logic               in_push,
  input  wire logic [2:0]         in_operation,
  input  wire logic [15:0]        in_user_index,
  input  wire logic [13:0]        in_item_index,
  input  wire logic signed [31:0] in_rating,
  input  wire logic [23:0]        in_update_order,
  input  wire logic [2:0]         in_element_index,
  input  wire logic signed [31:0] in_load_value,
  input  wire logic               cq_full,
  output logic                    cq_push,
  output mfs_pkg::cmd_t           cmd
);
  import mfs_pkg::*;

  logic u_ok, i_ok, e_ok;

  assign u_ok    = (32'(in_user_index) < 32'(USERS));
  assign i_ok    = (32'(in_item_index) < 32'(ITEMS));
  assign e_ok    = (32'(in_element_index) < 32'(RANK));
  assign cq_push = in_push && !cq_full;

  always_comb begin
    cmd.kind          = K_NOP;
    cmd.user_index    = in_user_index;
    cmd.item_index    = in_item_index;
    cmd.rating        = in_rating;
    cmd.seq_order     = in_update_order;
    cmd.element_index = in_element_index;
    cmd.load_value    = in_load_value;
    unique case (in_operation)
      OP_TRAIN:   if (u_ok && i_ok) cmd.kind = K_TRAIN;
      OP_WR_USER: if (u_ok && e_ok) cmd.kind = K_WU;
      OP_WR_ITEM: if (i_ok && e_ok) cmd.kind = K_WI;
      OP_RD_USER: if (u_ok && e_ok) cmd.kind = K_RU;
      OP_RD_ITEM: if (i_ok && e_ok) cmd.kind = K_RI;
      OP_EPOCH:   cmd.kind = K_EPOCH;
      default:    cmd.kind = K_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/mfs_back.sv =====
`default_nettype none

module mfs_back #(
  parameter int RANK  = 8,
  parameter int USERS = 65536,
  parameter int ITEMS = 16384
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mfs_pkg::cfg_t cfg,
  input  wire logic          cq_empty,
  input  wire mfs_pkg::cmd_t cq_cmd,
  output logic               cq_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output mfs_pkg::res_t      res
);
  import mfs_pkg::*;

  localparam int UW   = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int IW   = (ITEMS > 1) ? $clog2(ITEMS) : 1;
  localparam int UAW  = $clog2(USERS * RANK);
  localparam int IAW  = $clog2(ITEMS * RANK);
  localparam int JW   = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int MAXN = (USERS > ITEMS) ? USERS : ITEMS;
  localparam int CW   = $clog2(MAXN);

  typedef enum logic [23:0] {
    S_CLR  = 24'h000001, S_IDLE = 24'h000002, S_WR   = 24'h000004,
    S_RRD  = 24'h000008, S_RCAP = 24'h000010, S_LRD  = 24'h000020,
    S_LCAP = 24'h000040, S_DMUL = 24'h000080, S_DACC = 24'h000100,
    S_ERR  = 24'h000200, S_PSEL = 24'h000400, S_PAM  = 24'h000800,
    S_PAW  = 24'h001000, S_PBM  = 24'h002000, S_PBW  = 24'h004000,
    S_SMUL = 24'h008000, S_SCAP = 24'h010000, S_SU   = 24'h020000,
    S_SI   = 24'h040000, S_GU   = 24'h080000, S_GI   = 24'h100000,
    S_WU   = 24'h200000, S_ORDW = 24'h400000, S_PUSH = 24'h800000
  } state_t;

  state_t state_r, state_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [CW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_res_r, clr_res_nxt;
  logic          pw_sel_r, pw_sel_nxt;
  logic          j_last;

  cmd_t               cmd_r;
  res_t               res_r;
  logic signed [31:0] ur_r [RANK];
  logic signed [31:0] ir_r [RANK];
  logic signed [47:0] acc_r;
  logic signed [31:0] err_r, stepf_r, sv_r, si_r;
  logic [31:0]        us_r, is_r, pw_acc_r, pw_base_r;
  logic [23:0]        pw_e_r;
  wide_t              prod_r;
  mop_t               mul_a, mul_b;

  logic [31:0] uf_mem [USERS * RANK];
  logic [31:0] if_mem [ITEMS * RANK];
  logic [23:0] uo_mem [USERS];
  logic [23:0] io_mem [ITEMS];
  logic [31:0] uf_rd_r, if_rd_r;
  logic [23:0] uo_rd_r, io_rd_r;

  logic [UAW-1:0] ubase, uf_raddr, uf_waddr;
  logic [IAW-1:0] ibase, if_raddr, if_waddr;
  logic           uf_we, if_we, uo_we, io_we;
  logic [31:0]    uf_wdata, if_wdata;
  logic [UW-1:0]  uo_waddr;
  logic [IW-1:0]  io_waddr;
  logic [23:0]    ord_wdata;

  logic signed [25:0] skip;
  logic [23:0]        last_ord;
  wide_t              r31, r24;

  assign j_last   = (j_r == JW'(RANK - 1));
  assign ubase    = UAW'(UAW'(cmd_r.user_index) * UAW'(RANK));
  assign ibase    = IAW'(IAW'(cmd_r.item_index) * IAW'(RANK));
  assign uf_raddr = ubase + ((state_r == S_RRD) ? UAW'(cmd_r.element_index) : UAW'(j_r));
  assign if_raddr = ibase + ((state_r == S_RRD) ? IAW'(cmd_r.element_index) : IAW'(j_r));
  assign uf_waddr = ubase + ((state_r == S_WR) ? UAW'(cmd_r.element_index) : UAW'(j_r));
  assign if_waddr = ibase + ((state_r == S_WR) ? IAW'(cmd_r.element_index) : IAW'(j_r));
  assign r31      = rnd(prod_r, 31);
  assign r24      = rnd(prod_r, 24);
  assign last_ord = pw_sel_r ? io_rd_r : uo_rd_r;
  assign skip     = $signed({2'b00, cmd_r.seq_order}) - $signed({2'b00, last_ord}) - 26'sd1;

  always_comb begin
    uf_we    = 1'b0;
    if_we    = 1'b0;
    uf_wdata = cmd_r.load_value;
    if_wdata = cmd_r.load_value;
    if (state_r == S_WR) begin
      uf_we = (cmd_r.kind == K_WU);
      if_we = (cmd_r.kind == K_WI);
    end else if (state_r == S_GI) begin
      if_we    = 1'b1;
      if_wdata = sat32(wide_t'(si_r) - r24);
    end else if (state_r == S_WU) begin
      uf_we    = 1'b1;
      uf_wdata = sat32(wide_t'(sv_r) - r24);
    end
  end

  always_comb begin
    if (state_r == S_CLR) begin
      uo_we     = (32'(clr_cnt_r) < 32'(USERS));
      io_we     = (32'(clr_cnt_r) < 32'(ITEMS));
      uo_waddr  = UW'(clr_cnt_r);
      io_waddr  = IW'(clr_cnt_r);
      ord_wdata = '0;
    end else begin
      uo_we     = (state_r == S_ORDW) && cfg.reg_en;
      io_we     = (state_r == S_ORDW) && cfg.reg_en;
      uo_waddr  = UW'(cmd_r.user_index);
      io_waddr  = IW'(cmd_r.item_index);
      ord_wdata = cmd_r.seq_order;
    end
  end

  always_ff @(posedge clk) begin
    if (uf_we) uf_mem[uf_waddr] <= uf_wdata;
    if (if_we) if_mem[if_waddr] <= if_wdata;
    if (uo_we) uo_mem[uo_waddr] <= ord_wdata;
    if (io_we) io_mem[io_waddr] <= ord_wdata;
    uf_rd_r <= uf_mem[uf_raddr];
    if_rd_r <= if_mem[if_raddr];
    uo_rd_r <= uo_mem[UW'(cmd_r.user_index)];
    io_rd_r <= io_mem[IW'(cmd_r.item_index)];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DMUL: begin mul_a = sx(ur_r[j_r]);  mul_b = sx(ir_r[j_r]); end
      S_PAM:  begin mul_a = ux(pw_acc_r);   mul_b = ux(pw_base_r); end
      S_PBM:  begin mul_a = ux(pw_base_r);  mul_b = ux(pw_base_r); end
      S_SMUL: begin mul_a = ux(cfg.step_size); mul_b = sx(err_r); end
      S_SU:   begin mul_a = ux(us_r);       mul_b = sx(ur_r[j_r]); end
      S_SI:   begin mul_a = ux(is_r);       mul_b = sx(ir_r[j_r]); end
      S_GU:   begin mul_a = sx(stepf_r);    mul_b = sx(sv_r); end
      S_GI:   begin mul_a = sx(stepf_r);    mul_b = sx(si_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    j_nxt       = j_r;
    clr_cnt_nxt = clr_cnt_r;
    clr_res_nxt = clr_res_r;
    pw_sel_nxt  = pw_sel_r;
    cq_pop      = 1'b0;
    res_push    = 1'b0;
    unique case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CW'(MAXN - 1)) state_nxt = clr_res_r ? S_PUSH : S_IDLE;
      end
      S_IDLE: begin
        if (!cq_empty) begin
          cq_pop = 1'b1;
          j_nxt  = '0;
          unique case (cq_cmd.kind)
            K_TRAIN:    state_nxt = S_LRD;
            K_WU, K_WI: state_nxt = S_WR;
            K_RU, K_RI: state_nxt = S_RRD;
            K_EPOCH: begin
              state_nxt   = S_CLR;
              clr_cnt_nxt = '0;
              clr_res_nxt = 1'b1;
            end
            default:    state_nxt = S_PUSH;
          endcase
        end
      end
      S_WR:   state_nxt = S_PUSH;
      S_RRD:  state_nxt = S_RCAP;
      S_RCAP: state_nxt = S_PUSH;
      S_LRD:  state_nxt = S_LCAP;
      S_LCAP: begin
        j_nxt     = j_last ? '0 : j_r + 1'b1;
        state_nxt = j_last ? S_DMUL : S_LRD;
      end
      S_DMUL: state_nxt = S_DACC;
      S_DACC: begin
        j_nxt     = j_last ? '0 : j_r + 1'b1;
        state_nxt = j_last ? S_ERR : S_DMUL;
      end
      S_ERR: begin
        pw_sel_nxt = 1'b0;
        state_nxt  = S_PSEL;
      end
      S_PSEL: state_nxt = cfg.reg_en ? S_PAM : S_SMUL;
      S_PAM: begin
        if (pw_e_r == '0) begin
          pw_sel_nxt = 1'b1;
          state_nxt  = pw_sel_r ? S_SMUL : S_PSEL;
        end else begin
          state_nxt = pw_e_r[0] ? S_PAW : S_PBM;
        end
      end
      S_PAW:  state_nxt = S_PBM;
      S_PBM:  state_nxt = S_PBW;
      S_PBW:  state_nxt = S_PAM;
      S_SMUL: state_nxt = S_SCAP;
      S_SCAP: begin
        j_nxt     = '0;
        state_nxt = S_SU;
      end
      S_SU:   state_nxt = S_SI;
      S_SI:   state_nxt = S_GU;
      S_GU:   state_nxt = S_GI;
      S_GI:   state_nxt = S_WU;
      S_WU: begin
        j_nxt     = j_last ? '0 : j_r + 1'b1;
        state_nxt = j_last ? S_ORDW : S_SU;
      end
      S_ORDW: state_nxt = S_PUSH;
      S_PUSH: begin
        if (!res_full) begin
          res_push    = 1'b1;
          clr_res_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (state_r == S_IDLE && !cq_empty) begin
      cmd_r <= cq_cmd;
      res_r <= '0;
    end
    if (state_r == S_LCAP) begin
      ur_r[j_r] <= uf_rd_r;
      ir_r[j_r] <= if_rd_r;
    end
    if (state_r == S_LCAP && j_last) acc_r <= '0;
    if (state_r == S_DACC) acc_r <= acc_r + 48'(prod_r >>> 24);
    if (state_r == S_ERR) begin
      err_r <= sat32(wide_t'(acc_r) - wide_t'(cmd_r.rating) - wide_t'(cfg.mean_offset));
    end
    if (state_r == S_PSEL) begin
      pw_acc_r  <= ONE_Q31;
      pw_base_r <= (cfg.decay_base > ONE_Q31) ? ONE_Q31 : cfg.decay_base;
      pw_e_r    <= skip[25] ? '0 : skip[23:0];
      if (!cfg.reg_en) begin
        us_r <= ONE_Q31;
        is_r <= ONE_Q31;
      end
    end
    if (state_r == S_PAM && pw_e_r == '0) begin
      if (pw_sel_r) is_r <= pw_acc_r;
      else          us_r <= pw_acc_r;
    end
    if (state_r == S_PAW) pw_acc_r <= r31[31:0];
    if (state_r == S_PBW) begin
      pw_base_r <= r31[31:0];
      pw_e_r    <= pw_e_r >> 1;
    end
    if (state_r == S_SCAP) stepf_r <= sat32(rnd(prod_r, 32));
    if (state_r == S_SI)   sv_r    <= sat32(r31);
    if (state_r == S_GU)   si_r    <= sat32(r31);
    if (state_r == S_RCAP) res_r.read_value <= (cmd_r.kind == K_RU) ? uf_rd_r : if_rd_r;
    if (state_r == S_ORDW) res_r.prediction_error <= err_r;
    if (!rst_n) begin
      state_r   <= S_CLR;
      j_r       <= '0;
      clr_cnt_r <= '0;
      clr_res_r <= 1'b0;
      pw_sel_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      j_r       <= j_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      clr_res_r <= clr_res_nxt;
      pw_sel_r  <= pw_sel_nxt;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> state_r == S_IDLE) else $error("command taken while busy");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into full queue");
  a_pow_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PAM |-> (pw_base_r <= ONE_Q31 && pw_acc_r <= ONE_Q31))
    else $error("decay power above one");
  a_uf_write: assert property (@(posedge clk) disable iff (!rst_n)
    uf_we |-> (state_r == S_WU || state_r == S_WR)) else $error("stray factor write");

endmodule

`default_nettype wire

// ===== dv/matrix_factorization_sgd_step_tb.sv =====
`default_nettype none

module matrix_factorization_sgd_step_tb;
  import mfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int NRANK = 8;
  localparam longint ONE = 64'sd2147483648;

  typedef struct {
    logic [2:0]         op;
    logic [15:0]        user;
    logic [13:0]        item;
    logic signed [31:0] rating;
    logic [23:0]        order;
    logic [2:0]         el;
    logic signed [31:0] load;
  } word_t;

  typedef struct {
    logic signed [31:0] err;
    logic signed [31:0] rd;
  } sgd_out_t;

  typedef struct {
    word_t    w;
    bit       typed;
    sgd_out_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [2:0] in_operation = '0;
  logic [15:0] in_user_index = '0;
  logic [13:0] in_item_index = '0;
  logic signed [31:0] in_rating = '0;
  logic [23:0] in_update_order = '0;
  logic [2:0] in_element_index = '0;
  logic signed [31:0] in_load_value = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [31:0] out_prediction_error;
  logic signed [31:0] out_read_value;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  matrix_factorization_sgd_step u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_operation(in_operation), .in_user_index(in_user_index),
    .in_item_index(in_item_index), .in_rating(in_rating),
    .in_update_order(in_update_order), .in_element_index(in_element_index),
    .in_load_value(in_load_value),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_prediction_error(out_prediction_error), .out_read_value(out_read_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // shadow state
  logic [31:0]        m_step = RST_STEP_SIZE;
  logic [31:0]        m_decay = RST_DECAY_BASE;
  logic signed [31:0] m_ofs = '0;
  logic               m_reg = 1'b1;
  logic signed [31:0] user_fac[int];
  logic signed [31:0] item_fac[int];
  logic [23:0]        user_last[65536];
  logic [23:0]        item_last[16384];

  sgd_out_t expq[$];
  int fails = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_cycles = 0;
  logic [23:0] order_ctr = '0;

  int u_pool[8] = '{0, 1, 2, 3, 4, 5, 6, 65535};
  int i_pool[8] = '{0, 1, 2, 3, 4, 5, 6, 16383};

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  function automatic logic signed [31:0] clip(longint x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic longint decay_scale(logic [23:0] cur, logic [23:0] last);
    longint d;
    longint acc;
    longint b;
    logic [23:0] e;
    d = longint'(cur) - longint'(last) - 1;
    if (d < 0) d = 0;
    e = d[23:0];
    acc = ONE;
    b = (longint'(m_decay) > ONE) ? ONE : longint'(m_decay);
    for (int i = 0; i < 24; i++) begin
      if (e[i]) acc = (acc * b + (ONE >>> 1)) >>> 31;
      b = (b * b + (ONE >>> 1)) >>> 31;
    end
    return acc;
  endfunction

  function automatic sgd_out_t sgd_predict(word_t w);
    sgd_out_t r;
    longint dot, g, stepf, us, is, sv, si;
    logic signed [31:0] ou[NRANK];
    logic signed [31:0] oi[NRANK];
    int ub, ib;
    r.err = '0;
    r.rd = '0;
    ub = int'(w.user) * NRANK;
    ib = int'(w.item) * NRANK;
    case (w.op)
      OP_TRAIN: begin
        dot = 0;
        for (int j = 0; j < NRANK; j++) begin
          ou[j] = user_fac[ub + j];
          oi[j] = item_fac[ib + j];
          dot += (longint'(ou[j]) * longint'(oi[j])) >>> 24;
        end
        r.err = clip(dot - longint'(w.rating) - longint'(m_ofs));
        us = ONE;
        is = ONE;
        if (m_reg) begin
          us = decay_scale(w.order, user_last[w.user]);
          is = decay_scale(w.order, item_last[w.item]);
        end
        g = longint'(m_step) * longint'(r.err);
        stepf = (g + (64'sd1 <<< 31)) >>> 32;
        for (int j = 0; j < NRANK; j++) begin
          sv = longint'(clip((us * longint'(ou[j]) + (64'sd1 <<< 30)) >>> 31));
          si = longint'(clip((is * longint'(oi[j]) + (64'sd1 <<< 30)) >>> 31));
          user_fac[ub + j] = clip(sv - ((stepf * si + (64'sd1 <<< 23)) >>> 24));
          item_fac[ib + j] = clip(si - ((stepf * sv + (64'sd1 <<< 23)) >>> 24));
        end
        if (m_reg) begin
          user_last[w.user] = w.order;
          item_last[w.item] = w.order;
        end
      end
      OP_WR_USER: user_fac[ub + w.el] = w.load;
      OP_WR_ITEM: item_fac[ib + w.el] = w.load;
      OP_RD_USER: r.rd = user_fac[ub + w.el];
      OP_RD_ITEM: r.rd = item_fac[ib + w.el];
      OP_EPOCH: begin
        foreach (user_last[k]) user_last[k] = '0;
        foreach (item_last[k]) item_last[k] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit row_ready(bit is_user, int row);
    for (int j = 0; j < NRANK; j++) begin
      if (is_user && !user_fac.exists(row * NRANK + j)) return 1'b0;
      if (!is_user && !item_fac.exists(row * NRANK + j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] rand_val(int span);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int r, u, it;
    w.op = 3'($urandom);
    w.user = 16'($urandom);
    w.item = 14'($urandom);
    w.rating = $urandom;
    w.order = 24'($urandom);
    w.el = 3'($urandom);
    w.load = $urandom;
    u = u_pool[$urandom_range(0, 7)];
    it = i_pool[$urandom_range(0, 7)];
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 499) == 0) begin
      w.op = OP_EPOCH;
      return w;
    end
    if (r < 2) begin
      w.op = r[0] ? OP_SPARE7 : OP_SPARE6;
      return w;
    end
    if (r < 48) begin
      if (row_ready(1'b1, u) && row_ready(1'b0, it)) begin
        w.op = OP_TRAIN;
        w.user = 16'(u);
        w.item = 14'(it);
        w.rating = rand_val(1 << 26);
        if ($urandom_range(0, 19) == 0) w.order = 24'($urandom);
        else begin
          order_ctr = order_ctr + 24'($urandom_range(0, 3));
          w.order = order_ctr;
        end
        return w;
      end
      r = 60;
    end
    w.user = 16'(u);
    w.item = 14'(it);
    if (r < 75) begin
      w.op = $urandom_range(0, 1) ? OP_WR_USER : OP_WR_ITEM;
    end else begin
      w.op = $urandom_range(0, 1) ? OP_RD_USER : OP_RD_ITEM;
      if (w.op == OP_RD_USER && !user_fac.exists(u * NRANK + w.el)) w.op = OP_WR_USER;
      if (w.op == OP_RD_ITEM && !item_fac.exists(it * NRANK + w.el)) w.op = OP_WR_ITEM;
    end
    w.load = rand_val(1 << 24);
    return w;
  endfunction

  // called just after a falling edge; returns just after a falling edge
  task automatic send_word(word_t w, bit typed, sgd_out_t want);
    sgd_out_t p;
    while ($urandom_range(0, 99) < send_idle) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_operation = w.op;
    in_user_index = w.user;
    in_item_index = w.item;
    in_rating = w.rating;
    in_update_order = w.order;
    in_element_index = w.el;
    in_load_value = w.load;
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    p = sgd_predict(w);
    expq.insert(expq.size(), typed ? want : p);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_STEP_SIZE:  m_step = data;
      CFG_DECAY_BASE: m_decay = data;
      CFG_MEAN_OFS:   m_ofs = data;
      CFG_REG_EN:     m_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_push = 1'b0;
    while (expq.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_pop <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_pop <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expq.size() == 0) begin
        report_mismatch("unexpected word", out_prediction_error, '0);
      end else begin
        if (out_prediction_error !== expq[0].err)
          report_mismatch("prediction_error", out_prediction_error, expq[0].err);
        if (out_read_value !== expq[0].rd)
          report_mismatch("read_value", out_read_value, expq[0].rd);
        void'(expq.pop_front());
      end
    end
  end

  dir_row_t dir_tab[26] = '{
    '{'{OP_WR_USER, 16'd0, 14'd0, 32'sd0, 24'd0, 3'd0, 32'sh7fff_ffff}, 1'b1, '{0, 0}},
    '{'{OP_RD_USER, 16'd0, 14'd0, 32'sd0, 24'd0, 3'd0, 32'sd0}, 1'b1,
      '{0, 32'sh7fff_ffff}},
    '{'{OP_WR_USER, 16'hffff, 14'd0, 32'sd0, 24'd0, 3'd7, 32'sh8000_0000}, 1'b1, '{0, 0}},
    '{'{OP_RD_USER, 16'hffff, 14'd0, 32'sd0, 24'd0, 3'd7, 32'sd0}, 1'b1,
      '{0, 32'sh8000_0000}},
    '{'{OP_WR_ITEM, 16'd0, 14'h3fff, 32'sd0, 24'd0, 3'd7, 32'sh8000_0000}, 1'b1, '{0, 0}},
    '{'{OP_RD_ITEM, 16'd0, 14'h3fff, 32'sd0, 24'd0, 3'd7, 32'sd0}, 1'b1,
      '{0, 32'sh8000_0000}},
    '{'{OP_WR_USER, 16'd1, 14'd0, 32'sd0, 24'd0, 3'd0, 32'sh0100_0000}, 1'b0, '{0, 0}},
    '{'{OP_WR_USER, 16'd1, 14'd0, 32'sd0, 24'd0, 3'd1, 32'shff00_0000}, 1'b0, '{0, 0}},
    '{'{OP_WR_USER, 16'd1, 14'd0, 32'sd0, 24'd0, 3'd2, 32'sh0080_0000}, 1'b0, '{0, 0}},
    '{'{OP_WR_USER, 16'd1, 14'd0, 32'sd0, 24'd0, 3'd3, 32'sh7fff_ffff}, 1'b0, '{0, 0}},
    '{'{OP_WR_USER, 16'd1, 14'd0, 32'sd0, 24'd0, 3'd4, 32'sh8000_0000}, 1'b0, '{0, 0}},
    '{'{OP_WR_USER, 16'd1, 14'd0, 32'sd0, 24'd0, 3'd5, 32'sh0000_0001}, 1'b0, '{0, 0}},
    '{'{OP_WR_USER, 16'd1, 14'd0, 32'sd0, 24'd0, 3'd6, 32'shffff_ffff}, 1'b0, '{0, 0}},
    '{'{OP_WR_USER, 16'd1, 14'd0, 32'sd0, 24'd0, 3'd7, 32'sh0234_5678}, 1'b0, '{0, 0}},
    '{'{OP_WR_ITEM, 16'd0, 14'd1, 32'sd0, 24'd0, 3'd0, 32'sh0100_0000}, 1'b0, '{0, 0}},
    '{'{OP_WR_ITEM, 16'd0, 14'd1, 32'sd0, 24'd0, 3'd1, 32'sh0200_0000}, 1'b0, '{0, 0}},
    '{'{OP_WR_ITEM, 16'd0, 14'd1, 32'sd0, 24'd0, 3'd2, 32'shfe00_0000}, 1'b0, '{0, 0}},
    '{'{OP_WR_ITEM, 16'd0, 14'd1, 32'sd0, 24'd0, 3'd3, 32'sh7fff_ffff}, 1'b0, '{0, 0}},
    '{'{OP_WR_ITEM, 16'd0, 14'd1, 32'sd0, 24'd0, 3'd4, 32'sh7fff_ffff}, 1'b0, '{0, 0}},
    '{'{OP_WR_ITEM, 16'd0, 14'd1, 32'sd0, 24'd0, 3'd5, 32'sh8000_0000}, 1'b0, '{0, 0}},
    '{'{OP_WR_ITEM, 16'd0, 14'd1, 32'sd0, 24'd0, 3'd6, 32'sh0000_0000}, 1'b0, '{0, 0}},
    '{'{OP_WR_ITEM, 16'd0, 14'd1, 32'sd0, 24'd0, 3'd7, 32'shfedc_ba98}, 1'b0, '{0, 0}},
    '{'{OP_TRAIN, 16'd1, 14'd1, 32'sh7fff_ffff, 24'hff_ffff, 3'd0, 32'sd0}, 1'b0, '{0, 0}},
    '{'{OP_EPOCH, 16'd0, 14'd0, 32'sd0, 24'd0, 3'd0, 32'sd0}, 1'b1, '{0, 0}},
    '{'{OP_SPARE6, 16'hffff, 14'h3fff, 32'sh7fff_ffff, 24'hff_ffff, 3'd7, 32'shffff_ffff},
      1'b1, '{0, 0}},
    '{'{OP_SPARE7, 16'd1, 14'd1, 32'sh8000_0000, 24'd5, 3'd0, 32'sh7fff_ffff}, 1'b1, '{0, 0}}
  };

  logic [31:0] ph_step[4] = '{32'hffff_ffff, 32'd0, 32'h0100_0000, RST_STEP_SIZE};
  logic [31:0] ph_decay[4] = '{32'd0, ONE_Q31, 32'hffff_ffff, RST_DECAY_BASE};
  logic [31:0] ph_ofs[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'hff80_0000, 32'd0};
  logic [31:0] ph_reg[4] = '{32'd1, 32'd0, 32'hffff_fffe, 32'd1};
  int ph_send[4] = '{0, 85, 0, 11};
  int ph_recv[4] = '{0, 0, 85, 11};

  initial begin
    foreach (user_last[k]) user_last[k] = '0;
    foreach (item_last[k]) item_last[k] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[k]) send_word(dir_tab[k].w, dir_tab[k].typed, dir_tab[k].res);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      repeat (100) @(negedge clk);
      if (ph < 4) begin
        cfg_write(CFG_STEP_SIZE, ph_step[ph]);
        cfg_write(CFG_DECAY_BASE, ph_decay[ph]);
        cfg_write(CFG_MEAN_OFS, ph_ofs[ph]);
        cfg_write(CFG_REG_EN, ph_reg[ph]);
      end else begin
        cfg_write(CFG_STEP_SIZE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 24));
        cfg_write(CFG_DECAY_BASE, $urandom_range(0, 3) == 0 ? $urandom
                                  : 32'h8000_0000 - $urandom_range(0, 1 << 20));
        cfg_write(CFG_MEAN_OFS, rand_val(1 << 25));
        cfg_write(CFG_REG_EN, $urandom);
      end
      send_idle = ph_send[ph % 4];
      recv_stall = ph_recv[ph % 4];
      if (ph == 0) hold_cycles = 600;
      for (int n = 0; n < 250; n++) begin
        if (ph == 5 && n == 125) drain();
        send_word(rand_word(), 1'b0, '{0, 0});
      end
    end

    in_push = 1'b0;
    while (expq.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
